[rtl/stls_pkg.sv]
// Shared types, constants and helpers for the sorted time lower-bound search block.
// Used by stls_search and sorted_time_lower_bound_search_top; depends on nothing.
package stls_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 17;
    localparam int OUT_IDX_W   = 10;

    // request actions
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    // result status codes
    localparam logic [1:0] ST_FOUND   = 2'd0;
    localparam logic [1:0] ST_NONE    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    typedef logic [KEY_W-1:0] t_key;

    typedef struct packed {
        logic [1:0] action;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } t_in_req;

    typedef struct packed {
        logic [1:0]           status;
        logic [OUT_IDX_W-1:0] found_index;
        logic [4:0]           found_hours;
        logic [5:0]           found_minutes;
        logic [5:0]           found_seconds;
    } t_out_rsp;

    typedef struct packed {
        logic             start;
        logic             invalid;
        t_key             key;
        logic [CNT_W-1:0] count;
    } t_srch_cmd;

    typedef struct packed {
        logic             idle;
        logic             done;
        logic [1:0]       status;
        logic [CNT_W-1:0] index;
        t_key             key;
    } t_srch_rsp;

    function automatic logic time_valid(input logic [4:0] h, input logic [5:0] m,
                                        input logic [5:0] s);
        return (h < 5'd24) && (m < 6'd60) && (s < 6'd60);
    endfunction

    function automatic t_key make_key(input logic [4:0] h, input logic [5:0] m,
                                      input logic [5:0] s);
        return {h, m, s};
    endfunction

endpackage

[rtl/stls_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module stls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/stls_search.sv]
// Lower-bound search sequencer: one table probe per cycle through a shared compare unit.
// Depends on stls_pkg; drives the read port of the table RAM.
module stls_search (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  stls_pkg::t_srch_cmd            i_cmd,
    input  logic                           i_rsp_take,
    output stls_pkg::t_srch_rsp            o_rsp,
    output logic                           o_rd_en,
    output logic [stls_pkg::IDX_W-1:0]     o_rd_addr,
    input  stls_pkg::t_key                 i_rd_data
);

    localparam int CW = stls_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_FETCH  = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_lo, n_lo;
    logic [CW-1:0]   r_hi, n_hi;
    logic [CW-1:0]   r_mid, n_mid;
    stls_pkg::t_key  r_qkey, n_qkey;
    stls_pkg::t_key  r_found, n_found;
    logic [1:0]      r_status, n_status;

    logic            less;
    logic [CW-1:0]   step_lo, step_hi, step_mid, rd_idx;
    logic [CW:0]     step_sum;

    // shared compare unit and next probe point
    always_comb begin
        less     = i_rd_data < r_qkey;
        step_lo  = less ? (r_mid + CW'(1)) : r_lo;
        step_hi  = less ? r_hi : r_mid;
        step_sum = {1'b0, step_lo} + {1'b0, step_hi};
        step_mid = step_sum[CW:1];
    end

    always_comb begin
        n_state  = r_state;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_qkey   = r_qkey;
        n_found  = r_found;
        n_status = r_status;
        o_rd_en  = 1'b0;
        rd_idx   = r_mid;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_qkey  = i_cmd.key;
                    n_lo    = '0;
                    n_hi    = i_cmd.count;
                    n_found = '0;
                    if (i_cmd.invalid) begin
                        n_status = stls_pkg::ST_INVALID;
                        n_state  = S_DONE;
                    end else if (i_cmd.count == '0) begin
                        n_status = stls_pkg::ST_NONE;
                        n_state  = S_DONE;
                    end else begin
                        n_mid   = i_cmd.count >> 1;
                        rd_idx  = i_cmd.count >> 1;
                        o_rd_en = 1'b1;
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                n_lo = step_lo;
                n_hi = step_hi;
                if (step_lo < step_hi) begin
                    n_mid   = step_mid;
                    rd_idx  = step_mid;
                    o_rd_en = 1'b1;
                end else if (step_lo == i_cmd.count) begin
                    n_status = stls_pkg::ST_NONE;
                    n_state  = S_DONE;
                end else begin
                    // bound settled: fetch the entry at lo
                    rd_idx  = step_lo;
                    o_rd_en = 1'b1;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_found  = i_rd_data;
                n_status = stls_pkg::ST_FOUND;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_rsp_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_qkey   <= n_qkey;
        r_found  <= n_found;
        r_status <= n_status;
    end

    assign o_rd_addr    = rd_idx[stls_pkg::IDX_W-1:0];
    assign o_rsp.idle   = (r_state == S_IDLE);
    assign o_rsp.done   = (r_state == S_DONE);
    assign o_rsp.status = r_status;
    assign o_rsp.index  = r_lo;
    assign o_rsp.key    = r_found;

endmodule

[rtl/sorted_time_lower_bound_search_top.sv]
// Top level of the sorted time lower-bound search: request decode, entry count, table RAM,
// search sequencer and output register. Depends on stls_pkg, stls_ram and stls_search.
//
// Clear and load requests give no result and leave the search sequencer idle. A query makes
// one binary-search probe of the table per cycle, at most ceil(log2(entries + 1)) probes (11
// for a full table of 1024), then fetches the entry if one is found and hands the result to
// the output register; an invalid query or an empty table goes straight to the result. The
// next request can be taken once the result is registered. The single read port of the table
// RAM shapes the search: each probe's read data is compared and the next address issued in
// the same cycle. No new request is taken while a query is in progress; a finished result
// waits in the output register while the next request is taken.
module sorted_time_lower_bound_search_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  stls_pkg::t_in_req   i_in_req,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output stls_pkg::t_out_rsp  o_out_rsp
);

    localparam int CW = stls_pkg::CNT_W;

    logic [CW-1:0]          r_count, n_count;
    logic                   r_out_valid, n_out_valid;
    stls_pkg::t_out_rsp     r_out_rsp, n_out_rsp;

    logic                   accept, in_ok, out_free, rsp_take;
    logic                   wr_en, rd_en;
    logic [stls_pkg::IDX_W-1:0] rd_addr;
    stls_pkg::t_key         rd_data, in_key;
    stls_pkg::t_srch_cmd    cmd;
    stls_pkg::t_srch_rsp    rsp;

    assign o_in_stall = !rsp.idle;
    assign accept     = i_in_valid && rsp.idle;
    assign in_ok      = stls_pkg::time_valid(i_in_req.hours, i_in_req.minutes,
                                             i_in_req.seconds);
    assign in_key     = stls_pkg::make_key(i_in_req.hours, i_in_req.minutes,
                                           i_in_req.seconds);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign rsp_take   = rsp.done && out_free;

    always_comb begin
        n_count     = r_count;
        wr_en       = 1'b0;
        cmd.start   = 1'b0;
        cmd.invalid = !in_ok;
        cmd.key     = in_key;
        cmd.count   = r_count;
        if (accept) begin
            unique case (i_in_req.action)
                stls_pkg::ACT_CLEAR: begin
                    n_count = '0;
                end
                stls_pkg::ACT_LOAD: begin
                    // drop out-of-range times and loads into a full table
                    if (in_ok && (r_count < CW'(stls_pkg::TABLE_DEPTH))) begin
                        wr_en   = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                end
                stls_pkg::ACT_QUERY: begin
                    cmd.start = 1'b1;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_rsp   = r_out_rsp;
        if (out_free) begin
            n_out_valid = rsp.done;
            n_out_rsp   = '0;
            n_out_rsp.status = rsp.status;
            if (rsp.status == stls_pkg::ST_FOUND) begin
                n_out_rsp.found_index   = stls_pkg::OUT_IDX_W'(rsp.index);
                n_out_rsp.found_hours   = rsp.key[16:12];
                n_out_rsp.found_minutes = rsp.key[11:6];
                n_out_rsp.found_seconds = rsp.key[5:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_out_rsp <= n_out_rsp;
    end

    stls_ram #(
        .WIDTH (stls_pkg::KEY_W),
        .DEPTH (stls_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[stls_pkg::IDX_W-1:0]),
        .i_wr_data (in_key),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    stls_search u_search (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_rsp_take (rsp_take),
        .o_rsp      (rsp),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule

[test/stls_checker.sv]
// Result checker for the sorted time lower-bound search: watches both channels, keeps its own
// copy of the time table, predicts each query answer and compares it field by field.
// Depends on stls_pkg for the request and result types and the action and status codes.
module stls_result_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  stls_pkg::t_in_req  i_in_req,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  stls_pkg::t_out_rsp i_out_rsp,
    output int                 o_mismatches,
    output int                 o_answers_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import stls_pkg::*;

    logic [KEY_W-1:0] stored_times [TABLE_DEPTH];
    int unsigned      stored_count;
    t_out_rsp         owed_answers [$];
    int               mismatch_count = 0;
    int               owed_count = 0;

    assign o_mismatches   = mismatch_count;
    assign o_answers_owed = owed_count;

    function automatic bit clock_time_ok(input t_in_req req);
        return req.hours <= 5'd23 && req.minutes <= 6'd59 && req.seconds <= 6'd59;
    endfunction

    // First stored time not earlier than the query, by halving [lo, hi).
    function automatic t_out_rsp first_not_earlier(input t_in_req req);
        t_out_rsp         ans;
        logic [KEY_W-1:0] want_key;
        int unsigned      lo;
        int unsigned      hi;
        int unsigned      mid;
        ans = '0;
        if (!clock_time_ok(req)) begin
            ans.status = ST_INVALID;
            return ans;
        end
        want_key = {req.hours, req.minutes, req.seconds};
        lo = 0;
        hi = stored_count;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (stored_times[mid] < want_key)
                lo = mid + 1;
            else
                hi = mid;
        end
        if (lo >= stored_count) begin
            ans.status = ST_NONE;
            return ans;
        end
        ans.status        = ST_FOUND;
        ans.found_index   = lo[OUT_IDX_W-1:0];
        ans.found_hours   = stored_times[lo][16:12];
        ans.found_minutes = stored_times[lo][11:6];
        ans.found_seconds = stored_times[lo][5:0];
        return ans;
    endfunction

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_rsp want;
        if (!i_rst_n) begin
            stored_count = 0;
            owed_answers.delete();
            owed_count = 0;
        end else begin
            // retire the result first: it can never belong to a request taken at this edge
            if (i_out_valid && !i_out_stall) begin
                if (owed_answers.size() == 0) begin
                    $error("status: expected no result, got %0d", i_out_rsp.status);
                    mismatch_count++;
                end else begin
                    want = owed_answers.pop_front();
                    compare_field("status", want.status, i_out_rsp.status);
                    compare_field("found_index", want.found_index, i_out_rsp.found_index);
                    compare_field("found_hours", want.found_hours, i_out_rsp.found_hours);
                    compare_field("found_minutes", want.found_minutes,
                                  i_out_rsp.found_minutes);
                    compare_field("found_seconds", want.found_seconds,
                                  i_out_rsp.found_seconds);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_in_req.action)
                    ACT_CLEAR: begin
                        stored_count = 0;
                    end
                    ACT_LOAD: begin
                        if (stored_count < TABLE_DEPTH && clock_time_ok(i_in_req)) begin
                            stored_times[stored_count] =
                                {i_in_req.hours, i_in_req.minutes, i_in_req.seconds};
                            stored_count++;
                        end
                    end
                    ACT_QUERY: begin
                        owed_answers.insert(owed_answers.size(),
                                            first_not_earlier(i_in_req));
                    end
                    default: begin
                    end
                endcase
            end
            owed_count = owed_answers.size();
        end
    end

endmodule

[test/tb_sorted_time_lower_bound_search_top.sv]
// Testbench top for the sorted time lower-bound search: clock, reset, request stimulus,
// result-side stalls and the verdict. Depends on stls_pkg, the block and stls_result_checker.
module tb_sorted_time_lower_bound_search_top;
    timeunit 1ns;
    timeprecision 1ps;

    import stls_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int QUIET_LIMIT    = 3000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int DAY_SECONDS    = 86400;

    // action code the block ignores
    localparam logic [1:0] ACT_UNKNOWN = 2'd3;

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_stall;
    t_in_req  i_in_req;
    logic     o_out_valid;
    logic     i_out_stall;
    t_out_rsp o_out_rsp;
    int       mismatches;
    int       answers_owed;

    int       idle_pct;
    int       stall_pct;
    int       holdoff_asked;
    int       sent;

    int       idle_plan [4] = '{0, 52, 0, 25};
    int       stall_plan [4] = '{0, 0, 52, 25};

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    sorted_time_lower_bound_search_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    stls_result_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_in_req       (i_in_req),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out_rsp      (o_out_rsp),
        .o_mismatches   (mismatches),
        .o_answers_owed (answers_owed)
    );

    function automatic t_in_req make_request(input logic [1:0] act, input int unsigned h,
                                             input int unsigned m, input int unsigned s);
        t_in_req req;
        req.action  = act;
        req.hours   = h[4:0];
        req.minutes = m[5:0];
        req.seconds = s[5:0];
        return req;
    endfunction

    function automatic t_in_req time_request(input logic [1:0] act, input int unsigned secs);
        return make_request(act, secs / 3600, (secs / 60) % 60, secs % 60);
    endfunction

    // Query or load with at least one field past its clock range.
    function automatic t_in_req out_of_range_request(input logic [1:0] act);
        t_in_req req;
        req = make_request(act, $urandom_range(0, 31), $urandom_range(0, 63),
                           $urandom_range(0, 63));
        case ($urandom_range(0, 2))
            0:       req.hours   = $urandom_range(24, 31);
            1:       req.minutes = $urandom_range(60, 63);
            default: req.seconds = $urandom_range(60, 63);
        endcase
        return req;
    endfunction

    task automatic send_request(input t_in_req req);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_request(make_request(ACT_UNKNOWN, $urandom_range(0, 31),
                                         $urandom_range(0, 63), $urandom_range(0, 63)));
            1: send_request(out_of_range_request(ACT_LOAD));
            2: send_request(time_request(ACT_LOAD, $urandom_range(0, DAY_SECONDS - 1)));
            default: send_request(make_request(ACT_CLEAR, $urandom_range(0, 31),
                                               $urandom_range(0, 63), $urandom_range(0, 63)));
        endcase
    endtask

    // Load an ascending run of times, then query around them.
    task automatic fill_and_search(input int n_loads, input int n_queries, input bit full_run);
        int unsigned loaded [$];
        int unsigned t;
        int unsigned pick;
        int          k;
        int          kind;
        if (full_run || $urandom_range(0, 99) < 80)
            send_request(make_request(ACT_CLEAR, 0, 0, 0));
        t = full_run ? $urandom_range(0, 2000) : $urandom_range(0, 60000);
        for (k = 0; k < n_loads; k++) begin
            if (!full_run && $urandom_range(0, 99) < 8)
                send_noise();
            if (full_run)
                t += $urandom_range(0, 80);
            else if ($urandom_range(0, 6) != 0)
                t += $urandom_range(1, 6000);
            if (t >= DAY_SECONDS)
                t = DAY_SECONDS - 1;
            loaded.insert(loaded.size(), t);
            send_request(time_request(ACT_LOAD, t));
        end
        for (k = 0; k < n_queries; k++) begin
            if (!full_run && $urandom_range(0, 99) < 5)
                send_noise();
            kind = $urandom_range(0, 99);
            pick = (loaded.size() > 0) ? loaded[$urandom_range(0, loaded.size() - 1)] : 0;
            if (kind < 40 && loaded.size() > 0)
                send_request(time_request(ACT_QUERY, pick));
            else if (kind < 50 && loaded.size() > 0)
                send_request(time_request(ACT_QUERY, (pick + 1) % DAY_SECONDS));
            else if (kind < 75)
                send_request(time_request(ACT_QUERY, $urandom_range(0, DAY_SECONDS - 1)));
            else if (kind < 87)
                send_request(out_of_range_request(ACT_QUERY));
            else if (kind < 93)
                send_request(make_request(ACT_QUERY, 0, 0, 0));
            else
                send_request(make_request(ACT_QUERY, 23, 59, 59));
        end
    endtask

    // Result-side stalls; a requested hold-off keeps the output stalled for a long stretch.
    initial begin : result_stall
        int hold_left;
        int holdoff_served;
        hold_left      = 0;
        holdoff_served = 0;
        i_out_stall    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_asked != holdoff_served) begin
                holdoff_served = holdoff_asked;
                hold_left      = HOLDOFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    initial begin : quiet_watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int phase_end;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_req      = '0;
        idle_pct      = 0;
        stall_pct     = 0;
        holdoff_asked = 0;
        sent          = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, then every way a query time can be out of range
        send_request(make_request(ACT_QUERY, 12, 0, 0));
        send_request(make_request(ACT_QUERY, 24, 0, 0));
        send_request(make_request(ACT_QUERY, 31, 63, 63));
        send_request(make_request(ACT_QUERY, 0, 60, 0));
        send_request(make_request(ACT_QUERY, 0, 0, 60));
        // duplicates, dropped loads and an unknown action
        send_request(make_request(ACT_LOAD, 0, 0, 0));
        send_request(make_request(ACT_LOAD, 8, 30, 15));
        send_request(make_request(ACT_LOAD, 8, 30, 15));
        send_request(make_request(ACT_LOAD, 8, 30, 15));
        send_request(make_request(ACT_LOAD, 24, 10, 10));
        send_request(make_request(ACT_LOAD, 12, 61, 0));
        send_request(make_request(ACT_UNKNOWN, 31, 63, 63));
        send_request(make_request(ACT_LOAD, 23, 59, 59));
        send_request(make_request(ACT_QUERY, 0, 0, 0));
        send_request(make_request(ACT_QUERY, 8, 30, 15));
        send_request(make_request(ACT_QUERY, 8, 30, 16));
        send_request(make_request(ACT_QUERY, 23, 59, 59));
        // out-of-order load
        send_request(make_request(ACT_LOAD, 6, 0, 0));
        send_request(make_request(ACT_QUERY, 7, 0, 0));
        send_request(make_request(ACT_QUERY, 23, 59, 59));
        send_request(make_request(ACT_CLEAR, 0, 0, 0));
        send_request(make_request(ACT_QUERY, 0, 0, 0));
        send_request(make_request(ACT_LOAD, 23, 59, 59));
        send_request(make_request(ACT_QUERY, 23, 59, 59));
        send_request(make_request(ACT_QUERY, 0, 0, 0));

        for (phase = 0; phase < 4; phase++) begin
            idle_pct  = idle_plan[phase];
            stall_pct = stall_plan[phase];
            if (phase == 0)
                holdoff_asked++;
            phase_end = sent + ITEMS_PER_PHASE;
            if (phase == 3)
                fill_and_search(TABLE_DEPTH + 3, 40, 1'b1);
            while (sent < phase_end) begin
                fill_and_search(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24),
                                $urandom_range(1, 12), 1'b0);
            end
        end
        i_in_valid <= 1'b0;
        stall_pct  = 25;

        @(posedge i_clk);
        while (answers_owed != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sorted_time_lower_bound_search_top.f]
rtl/stls_pkg.sv
rtl/stls_ram.sv
rtl/stls_search.sv
rtl/sorted_time_lower_bound_search_top.sv
test/stls_checker.sv
test/tb_sorted_time_lower_bound_search_top.sv
